/* hw/rtl/ntf_pkg.sv */
// ----------------------------------------------------------------------------
// ntf_pkg: shared constants and types of the normalized term frequency counter
// Sizes of the term table, the text window and the counters, plus the control
// groups that the top level hands to the window cells and the term units.
// ----------------------------------------------------------------------------
`default_nettype none

package ntf_pkg;

    localparam int NUM_TERMS  = 8;
    localparam int TERM_LEN   = 16;
    localparam int COUNT_BITS = 16;

    localparam int LEN_W  = $clog2(TERM_LEN + 1);
    localparam int POS_W  = (TERM_LEN > 1) ? $clog2(TERM_LEN) : 1;
    localparam int TIDX_W = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;

    localparam int MODE_W   = 2;
    localparam int TERM_W   = 3;
    localparam int CPOS_W   = 4;
    localparam int VALUE_W  = 8;
    localparam int MCOUNT_W = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_CHAR = 2'd0,
        MODE_SET_LEN   = 2'd1,
        MODE_TEXT      = 2'd2,
        MODE_END       = 2'd3
    } t_mode;

    typedef logic [VALUE_W-1:0]    t_byte;
    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_win_ctl;

    typedef struct packed {
        logic              char_we;
        logic              len_we;
        logic              step;
        logic              clear;
        logic [CPOS_W-1:0] pos;
        t_byte             value;
    } t_term_ctl;

endpackage

`default_nettype wire

/* hw/rtl/normalized_term_frequency_counter.sv */
// ----------------------------------------------------------------------------
// normalized_term_frequency_counter: counts table terms in normalized text
// Loads up to eight terms, normalizes a text byte stream and reports one
// saturating match count per term at end of text.
//
//   channel  direction  handshake                payload
//   in       request    i_in_valid / o_in_ready   i_mode i_term_index
//                                                 i_char_position i_value
//   out      result     o_out_valid / i_out_ready o_term_number
//                                                 o_match_count o_last
//
// A text byte shifts the window cell row and updates all term counters in the
// cycle it is accepted. End of text copies the counts into a report shift
// line and clears the text state; the report drains one count per cycle
// while i_out_ready is high.
// Text and load requests keep flowing while the report drains; a second end
// of text waits until the report line is empty.
// After reset all terms are disabled and all counts are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module normalized_term_frequency_counter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [ntf_pkg::MODE_W-1:0]    i_mode,
    input  wire logic [ntf_pkg::TERM_W-1:0]    i_term_index,
    input  wire logic [ntf_pkg::CPOS_W-1:0]    i_char_position,
    input  wire logic [ntf_pkg::VALUE_W-1:0]   i_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [ntf_pkg::TERM_W-1:0]         o_term_number,
    output logic [ntf_pkg::MCOUNT_W-1:0]       o_match_count,
    output logic                               o_last
);

    localparam int NT = ntf_pkg::NUM_TERMS;
    localparam int TL = ntf_pkg::TERM_LEN;
    localparam int XW = ntf_pkg::TIDX_W;

    localparam ntf_pkg::t_byte ESC_BYTE    = 8'h1B;
    localparam ntf_pkg::t_byte SPACE_BYTE  = 8'h20;
    localparam ntf_pkg::t_byte QUOTE_BYTE  = 8'h22;
    localparam ntf_pkg::t_byte DOLLAR_BYTE = 8'h24;
    localparam ntf_pkg::t_byte TAB_BYTE    = 8'h09;
    localparam ntf_pkg::t_byte LOWER_A     = 8'h61;
    localparam ntf_pkg::t_byte LOWER_Z     = 8'h7A;
    localparam ntf_pkg::t_byte CASE_OFFSET = 8'h20;

    logic w_in_fire, w_out_fire;
    logic w_load_char, w_set_len, w_text, w_end;
    logic r_esc, n_esc;
    ntf_pkg::t_byte w_norm;

    ntf_pkg::t_win_ctl                      w_win_ctl;
    ntf_pkg::t_byte [TL-1:0]                w_view;
    logic [TL-1:0]                          w_view_valid;
    ntf_pkg::t_byte [TL-2:0]                w_cell_byte;
    logic [TL-2:0]                          w_cell_valid;

    ntf_pkg::t_term_ctl                     w_term_ctl [NT];
    ntf_pkg::t_count                        w_count    [NT];

    ntf_pkg::t_count                        r_rep_count [NT];
    logic [XW-1:0]                          r_rep_num;
    logic                                   r_rep_busy;
    logic                                   w_rep_last;

    // hold a new end of text until the previous report is out
    assign o_in_ready = !(r_rep_busy && (ntf_pkg::t_mode'(i_mode) == ntf_pkg::MODE_END));
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_fire = r_rep_busy && i_out_ready;

    always_comb begin
        w_load_char = 1'b0;
        w_set_len   = 1'b0;
        w_text      = 1'b0;
        w_end       = 1'b0;
        unique case (ntf_pkg::t_mode'(i_mode))
            ntf_pkg::MODE_LOAD_CHAR: w_load_char = 1'b1;
            ntf_pkg::MODE_SET_LEN:   w_set_len   = 1'b1;
            ntf_pkg::MODE_TEXT:      w_text      = 1'b1;
            ntf_pkg::MODE_END:       w_end       = 1'b1;
        endcase
    end

    always_comb begin
        w_norm = i_value;
        if (r_esc || (i_value == ESC_BYTE)) begin
            w_norm = SPACE_BYTE;
        end else begin
            if ((i_value >= LOWER_A) && (i_value <= LOWER_Z)) begin
                w_norm = i_value - CASE_OFFSET;
            end
            if ((w_norm == QUOTE_BYTE) || (w_norm == DOLLAR_BYTE) || (w_norm == TAB_BYTE)) begin
                w_norm = SPACE_BYTE;
            end
        end
    end

    always_comb begin
        n_esc = r_esc;
        if (w_in_fire && w_text) begin
            n_esc = !r_esc && (i_value == ESC_BYTE);
        end else if (w_in_fire && w_end) begin
            n_esc = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
        end else begin
            r_esc <= n_esc;
        end
    end

    assign w_win_ctl.shift = w_in_fire && w_text;
    assign w_win_ctl.clear = w_in_fire && w_end;

    for (genvar j = 0; j < TL; j++) begin : g_win
        if (j == 0) begin : g_head
            assign w_view[j]       = w_norm;
            assign w_view_valid[j] = 1'b1;
        end else begin : g_body
            assign w_view[j]       = w_cell_byte[j-1];
            assign w_view_valid[j] = w_cell_valid[j-1];
        end
        if (j < TL - 1) begin : g_cell
            ntf_win_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_win_ctl),
                .i_byte  (w_view[j]),
                .i_valid (w_view_valid[j]),
                .o_byte  (w_cell_byte[j]),
                .o_valid (w_cell_valid[j])
            );
        end
    end

    always_comb begin
        for (int t = 0; t < NT; t++) begin
            w_term_ctl[t].char_we = w_in_fire && w_load_char
                                    && (32'(i_term_index) == 32'(t))
                                    && (32'(i_char_position) < 32'(TL));
            w_term_ctl[t].len_we  = w_in_fire && w_set_len
                                    && (32'(i_term_index) == 32'(t));
            w_term_ctl[t].step    = w_in_fire && w_text;
            w_term_ctl[t].clear   = w_in_fire && w_end;
            w_term_ctl[t].pos     = i_char_position;
            w_term_ctl[t].value   = i_value;
        end
    end

    for (genvar t = 0; t < NT; t++) begin : g_term
        ntf_term_unit u_term (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctl          (w_term_ctl[t]),
            .i_window       (w_view),
            .i_window_valid (w_view_valid),
            .o_count        (w_count[t])
        );
    end

    assign w_rep_last = (r_rep_num == XW'(NT - 1));

    // capture counts at end of text, advance the line on each taken result
    always_ff @(posedge i_clk) begin
        if (w_in_fire && w_end) begin
            for (int t = 0; t < NT; t++) begin
                r_rep_count[t] <= w_count[t];
            end
        end else if (w_out_fire) begin
            for (int t = 0; t < NT - 1; t++) begin
                r_rep_count[t] <= r_rep_count[t+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_busy <= 1'b0;
            r_rep_num  <= '0;
        end else if (w_in_fire && w_end) begin
            r_rep_busy <= 1'b1;
            r_rep_num  <= '0;
        end else if (w_out_fire) begin
            r_rep_num <= r_rep_num + XW'(1);
            if (w_rep_last) begin
                r_rep_busy <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_rep_busy;
    assign o_term_number = ntf_pkg::TERM_W'(r_rep_num);
    assign o_match_count = ntf_pkg::MCOUNT_W'(r_rep_count[0]);
    assign o_last        = w_rep_last;

    a_rep_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_end) |=> (o_out_valid && (r_rep_num == '0)))
        else $error("report does not start at term zero");

    a_rep_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && !o_last) |=> (o_out_valid && (r_rep_num == $past(r_rep_num) + XW'(1))))
        else $error("report skipped or repeated a term");

    a_rep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && o_last) |=> !o_out_valid)
        else $error("report runs past its last term");

    a_text_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_end) |=> ((w_cell_valid == '0) && !r_esc))
        else $error("window or escape not cleared at end of text");

endmodule

`default_nettype wire

/* hw/rtl/ntf_win_cell.sv */
// ----------------------------------------------------------------------------
// ntf_win_cell: one byte cell of the text window
// Holds one normalized byte and its fill flag; on each text byte it takes the
// contents of its left neighbor, on end of text it empties.
// ----------------------------------------------------------------------------
`default_nettype none

module ntf_win_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ntf_pkg::t_win_ctl i_ctl,
    input  wire ntf_pkg::t_byte   i_byte,
    input  wire logic             i_valid,
    output ntf_pkg::t_byte        o_byte,
    output logic                  o_valid
);

    ntf_pkg::t_byte r_byte, n_byte;
    logic           r_valid, n_valid;

    always_comb begin
        n_byte  = r_byte;
        n_valid = r_valid;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.shift) begin
            n_byte  = i_byte;
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

/* hw/rtl/ntf_term_unit.sv */
// ----------------------------------------------------------------------------
// ntf_term_unit: one term of the table with its match counter
// Stores the term characters and length, compares them against the window as
// it stands after the current byte, and counts non-overlapping matches.
// ----------------------------------------------------------------------------
`default_nettype none

module ntf_term_unit (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire ntf_pkg::t_term_ctl                          i_ctl,
    input  wire ntf_pkg::t_byte [ntf_pkg::TERM_LEN-1:0]      i_window,
    input  wire logic [ntf_pkg::TERM_LEN-1:0]                i_window_valid,
    output ntf_pkg::t_count                                  o_count
);

    localparam int TL = ntf_pkg::TERM_LEN;
    localparam int LW = ntf_pkg::LEN_W;
    localparam int PW = ntf_pkg::POS_W;
    localparam int CW = ntf_pkg::COUNT_BITS;

    ntf_pkg::t_byte  r_char [TL];
    logic [LW-1:0]   r_len, n_len;
    ntf_pkg::t_count r_count, n_count;
    logic [PW-1:0]   r_block, n_block;
    logic [LW-1:0]   w_last;
    logic            w_hit;

    assign w_last = r_len - LW'(1);

    always_comb begin : p_match
        logic [LW-1:0] v_j;
        v_j   = '0;
        w_hit = (r_len != '0) && i_window_valid[w_last[PW-1:0]];
        for (int k = 0; k < TL; k++) begin
            v_j = w_last - LW'(k);
            if ((LW'(k) < r_len) && (i_window[v_j[PW-1:0]] != r_char[k])) begin
                w_hit = 1'b0;
            end
        end
    end

    always_comb begin
        n_len   = r_len;
        n_count = r_count;
        n_block = r_block;
        if (i_ctl.len_we) begin
            n_len = (i_ctl.value > 8'(TL)) ? LW'(TL) : LW'(i_ctl.value);
        end
        if (i_ctl.clear) begin
            n_count = '0;
            n_block = '0;
        end else if (i_ctl.step) begin
            if (r_block != '0) begin
                n_block = r_block - PW'(1);
            end else if (w_hit) begin
                if (r_count != '1) begin
                    n_count = r_count + CW'(1);
                end
                n_block = w_last[PW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_count <= '0;
            r_block <= '0;
        end else begin
            r_len   <= n_len;
            r_count <= n_count;
            r_block <= n_block;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.char_we) begin
            r_char[PW'(i_ctl.pos)] <= i_ctl.value;
        end
    end

    assign o_count = r_count;

endmodule

`default_nettype wire

/* tb/sv/normalized_term_frequency_counter_tb.sv */
// ----------------------------------------------------------------------------
// normalized_term_frequency_counter_tb: term table loading and text counting
// A walked table of directed requests (extremes, normalization, escapes, a
// repeated byte run) is followed by random requests. Request and result sides
// stall at random. Every reported count is checked against a tracking copy
// of the term table, text window and per-term counters.
// ----------------------------------------------------------------------------

module normalized_term_frequency_counter_tb;

    localparam int NT = ntf_pkg::NUM_TERMS;
    localparam int TL = ntf_pkg::TERM_LEN;
    localparam int LW = ntf_pkg::LEN_W;
    localparam int MW = ntf_pkg::MODE_W;
    localparam int TW = ntf_pkg::TERM_W;
    localparam int PW = ntf_pkg::CPOS_W;
    localparam int VW = ntf_pkg::VALUE_W;
    localparam int CW = ntf_pkg::MCOUNT_W;

    localparam logic [7:0] BYTE_ESC    = 8'h1B;
    localparam logic [7:0] BYTE_DQUOTE = 8'h22;
    localparam logic [7:0] BYTE_DOLLAR = 8'h24;
    localparam logic [7:0] BYTE_TAB    = 8'h09;
    localparam logic [7:0] BYTE_SPACE  = 8'h20;

    localparam int RANDOM_REQUESTS = 180;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int IDLE_PCT        = 19;

    typedef struct packed {
        ntf_pkg::t_mode      mode;
        logic [TW-1:0]       idx;
        logic [PW-1:0]       pos;
        logic [VW-1:0]       val;
        logic [16:0]         rpt;
        logic                zero_rep;
    } t_stim_row;

    typedef struct packed {
        logic [TW-1:0]       term;
        logic [CW-1:0]       cnt;
        logic                last;
    } t_count_rec;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [MW-1:0]       i_mode;
    logic [TW-1:0]       i_term_index;
    logic [PW-1:0]       i_char_position;
    logic [VW-1:0]       i_value;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [TW-1:0]       o_term_number;
    logic [CW-1:0]       o_match_count;
    logic                o_last;

    logic [7:0]          tf_chars [NT][TL];
    bit                  chr_written [NT][TL];
    logic [LW-1:0]       tf_len [NT];
    logic [7:0]          window [TL];
    int                  win_fill;
    logic [CW-1:0]       tf_count [NT];
    int                  hold_off [NT];
    bit                  esc_armed;

    t_count_rec          pending_counts [$];
    t_stim_row           plan [$];
    int                  errors;
    int                  cycle_cnt;
    bit                  no_stall;

    normalized_term_frequency_counter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_term_index    (i_term_index),
        .i_char_position (i_char_position),
        .i_value         (i_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_term_number   (o_term_number),
        .o_match_count   (o_match_count),
        .o_last          (o_last)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic logic [7:0] pick_term_char();
        case ($urandom_range(0, 3))
            0: return "A";
            1: return "B";
            2: return BYTE_SPACE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic score_request(input ntf_pkg::t_mode m, input logic [TW-1:0] ti,
                                 input logic [PW-1:0] cp, input logic [7:0] v,
                                 input bit zero_rep);
        logic [7:0] b;
        bit         hit;
        int         len;
        t_count_rec rec;
        case (m)
            ntf_pkg::MODE_LOAD_CHAR: begin
                tf_chars[ti][cp] = v;
                chr_written[ti][cp] = 1'b1;
            end
            ntf_pkg::MODE_SET_LEN: begin
                tf_len[ti] = (v > 8'(TL)) ? LW'(TL) : LW'(v);
            end
            ntf_pkg::MODE_TEXT: begin
                if (esc_armed) begin
                    b = BYTE_SPACE;
                    esc_armed = 1'b0;
                end else if (v == BYTE_ESC) begin
                    b = BYTE_SPACE;
                    esc_armed = 1'b1;
                end else begin
                    b = v;
                    if (b >= "a" && b <= "z")
                        b = b - 8'h20;
                    if (b == BYTE_DQUOTE || b == BYTE_DOLLAR || b == BYTE_TAB)
                        b = BYTE_SPACE;
                end
                for (int k = TL - 1; k > 0; k--)
                    window[k] = window[k-1];
                window[0] = b;
                if (win_fill < TL)
                    win_fill++;
                for (int t = 0; t < NT; t++) begin
                    len = int'(tf_len[t]);
                    if (hold_off[t] > 0) begin
                        hold_off[t]--;
                    end else begin
                        hit = (len > 0) && (win_fill >= len);
                        for (int k = 0; k < len; k++)
                            if (tf_chars[t][k] != window[len-1-k])
                                hit = 1'b0;
                        if (hit) begin
                            if (tf_count[t] != '1)
                                tf_count[t]++;
                            hold_off[t] = len - 1;
                        end
                    end
                end
            end
            default: begin
                for (int t = 0; t < NT; t++) begin
                    rec.term = TW'(t);
                    rec.cnt  = zero_rep ? '0 : tf_count[t];
                    rec.last = (t == NT - 1);
                    pending_counts.push_back(rec);
                    tf_count[t] = '0;
                    hold_off[t] = 0;
                end
                win_fill = 0;
                esc_armed = 1'b0;
            end
        endcase
    endtask

    task automatic send_request(input ntf_pkg::t_mode m, input logic [TW-1:0] ti,
                                input logic [PW-1:0] cp, input logic [7:0] v,
                                input bit zero_rep);
        while (!no_stall && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      = 1'b1;
        i_mode          = m;
        i_term_index    = ti;
        i_char_position = cp;
        i_value         = v;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        score_request(m, ti, cp, v, zero_rep);
        @(negedge i_clk);
    endtask

    // load any missing characters below the new length first
    task automatic arm_length(input logic [TW-1:0] ti, input logic [7:0] v);
        int eff;
        eff = (v > 8'(TL)) ? TL : int'(v);
        for (int p = 0; p < eff; p++)
            if (!chr_written[ti][p])
                send_request(ntf_pkg::MODE_LOAD_CHAR, ti, PW'(p), pick_term_char(), 1'b0);
        send_request(ntf_pkg::MODE_SET_LEN, ti, PW'($urandom_range(0, 15)), v, 1'b0);
    endtask

    always @(posedge i_clk) begin
        t_count_rec rec;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_counts.size() == 0) begin
                $display("%0t: unexpected count: term %0d count %0d last %0d",
                         $time, o_term_number, o_match_count, o_last);
                errors = errors + 1;
            end else begin
                rec = pending_counts.pop_front();
                if (o_term_number !== rec.term) begin
                    $display("%0t: term_number expected %0d actual %0d",
                             $time, rec.term, o_term_number);
                    errors = errors + 1;
                end
                if (o_match_count !== rec.cnt) begin
                    $display("%0t: match_count of term %0d expected %0d actual %0d",
                             $time, rec.term, rec.cnt, o_match_count);
                    errors = errors + 1;
                end
                if (o_last !== rec.last) begin
                    $display("%0t: last of term %0d expected %0d actual %0d",
                             $time, rec.term, rec.last, o_last);
                    errors = errors + 1;
                end
            end
        end
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = no_stall || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge i_clk);
        $display("normalized_term_frequency_counter_tb: done, errors");
        $finish;
    end

    initial begin
        logic [7:0]       v;
        int               r;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_mode          = ntf_pkg::MODE_LOAD_CHAR;
        i_term_index    = '0;
        i_char_position = '0;
        i_value         = '0;
        errors          = 0;
        cycle_cnt       = 0;
        no_stall        = 1'b0;
        win_fill        = 0;
        esc_armed       = 1'b0;
        for (int t = 0; t < NT; t++) begin
            tf_len[t]   = '0;
            tf_count[t] = '0;
            hold_off[t] = 0;
            for (int p = 0; p < TL; p++) begin
                tf_chars[t][p]    = '0;
                chr_written[t][p] = 1'b0;
            end
        end

        plan.push_back('{ntf_pkg::MODE_END,       3'd0, 4'd0,  8'h00,       17'd1,  1'b1});
        plan.push_back('{ntf_pkg::MODE_LOAD_CHAR, 3'd0, 4'd0,  "A",         17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_LOAD_CHAR, 3'd0, 4'd1,  "B",         17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_SET_LEN,   3'd0, 4'd0,  8'd2,        17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_LOAD_CHAR, 3'd7, 4'd15, 8'hFF,       17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_LOAD_CHAR, 3'd7, 4'd0,  BYTE_SPACE,  17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_SET_LEN,   3'd7, 4'd0,  8'd1,        17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_SET_LEN,   3'd2, 4'd0,  8'hFF,       17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_LOAD_CHAR, 3'd3, 4'd0,  "Z",         17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_SET_LEN,   3'd3, 4'd0,  8'd1,        17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_TEXT,      3'd0, 4'd0,  "a",         17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_TEXT,      3'd0, 4'd0,  "B",         17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_TEXT,      3'd0, 4'd0,  BYTE_DQUOTE, 17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_TEXT,      3'd0, 4'd0,  "A",         17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_TEXT,      3'd0, 4'd0,  BYTE_ESC,    17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_TEXT,      3'd0, 4'd0,  BYTE_ESC,    17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_TEXT,      3'd0, 4'd0,  "b",         17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_TEXT,      3'd0, 4'd0,  BYTE_TAB,    17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_TEXT,      3'd0, 4'd0,  BYTE_DOLLAR, 17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_TEXT,      3'd0, 4'd0,  8'h00,       17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_TEXT,      3'd0, 4'd0,  "Z",         17'd20, 1'b0});
        plan.push_back('{ntf_pkg::MODE_TEXT,      3'd0, 4'd0,  BYTE_ESC,    17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_END,       3'd0, 4'd0,  8'h00,       17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_TEXT,      3'd0, 4'd0,  "Z",         17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_END,       3'd0, 4'd0,  8'h00,       17'd1,  1'b0});
        plan.push_back('{ntf_pkg::MODE_END,       3'd0, 4'd0,  8'h00,       17'd1,  1'b1});

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].mode == ntf_pkg::MODE_SET_LEN)
                arm_length(plan[i].idx, plan[i].val);
            else
                repeat (plan[i].rpt)
                    send_request(plan[i].mode, plan[i].idx, plan[i].pos,
                                 plan[i].val, plan[i].zero_rep);
        end

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            no_stall = (n >= 100 && n < 160);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_request(ntf_pkg::MODE_END, TW'($urandom_range(0, 7)),
                             PW'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), 1'b0);
            end else if (r < 16) begin
                send_request(ntf_pkg::MODE_LOAD_CHAR, TW'($urandom_range(0, 7)),
                             PW'($urandom_range(0, 15)), pick_term_char(), 1'b0);
            end else if (r < 22) begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    v = 8'($urandom_range(0, 3));
                else if (r < 9)
                    v = 8'($urandom_range(0, 16));
                else
                    v = 8'($urandom_range(17, 255));
                arm_length(TW'($urandom_range(0, 7)), v);
            end else begin
                case ($urandom_range(0, 14))
                    0, 1:    v = "A";
                    2, 3:    v = "B";
                    4:       v = "a";
                    5:       v = "b";
                    6:       v = BYTE_SPACE;
                    7:       v = BYTE_DQUOTE;
                    8:       v = BYTE_DOLLAR;
                    9:       v = BYTE_TAB;
                    10:      v = BYTE_ESC;
                    default: v = 8'($urandom_range(0, 255));
                endcase
                send_request(ntf_pkg::MODE_TEXT, TW'($urandom_range(0, 7)),
                             PW'($urandom_range(0, 15)), v, 1'b0);
            end
        end
        no_stall = 1'b0;
        send_request(ntf_pkg::MODE_END, 3'd0, 4'd0, 8'h00, 1'b0);
        i_in_valid = 1'b0;

        while (pending_counts.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (errors == 0)
            $display("normalized_term_frequency_counter_tb: done, clean");
        else
            $display("normalized_term_frequency_counter_tb: done, errors");
        $finish;
    end

endmodule
